@@ sv/pitp_pkg.sv @@
`default_nettype none

package pitp_pkg;

  // configuration port
  localparam int CFG_DATA_W = 63;
  localparam int CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_VERTEX_A     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VERTEX_B     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_VERTEX_C     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PRISM_LENGTH = 2'd3;

  // prism length is unsigned, same scale as the coordinates
  localparam int LEN_BITS = 20;

  // number of register stages from input to output register
  localparam int NUM_STAGES = 7;

  // stage flow-control flags handed to the wide multipliers
  typedef struct packed {
    logic en_a;
    logic en_b;
  } mul_ctl_t;

endpackage

`default_nettype wire

@@ sv/pitp_wmul.sv @@
`default_nettype none

module pitp_wmul #(
  parameter int W = 45
) (
  input  logic                  clk,
  input  pitp_pkg::mul_ctl_t    ctl,
  input  logic signed [W-1:0]   a,
  input  logic signed [W-1:0]   b,
  output logic signed [2*W-1:0] p
);
  import pitp_pkg::*;

  localparam int LO = (W + 1) / 2;
  localparam int HI = W - LO;
  localparam int PW = 2 * W;
  localparam int XW = HI + LO + 1;

  logic        [LO-1:0]   al, bl;
  logic signed [HI-1:0]   ah, bh;
  logic signed [2*HI-1:0] hh_nxt, hh_r;
  logic signed [XW-1:0]   hl_nxt, hl_r, lh_nxt, lh_r;
  logic        [2*LO-1:0] ll_nxt, ll_r;
  logic signed [PW-1:0]   p_nxt, p_r;

  // split each operand into signed high half and unsigned low half
  assign al = a[LO-1:0];
  assign bl = b[LO-1:0];
  assign ah = $signed(a[W-1:LO]);
  assign bh = $signed(b[W-1:LO]);

  assign hh_nxt = ah * bh;
  assign hl_nxt = ah * $signed({1'b0, bl});
  assign lh_nxt = $signed({1'b0, al}) * bh;
  assign ll_nxt = al * bl;

  always_ff @(posedge clk) begin
    if (ctl.en_a) begin
      hh_r <= hh_nxt;
      hl_r <= hl_nxt;
      lh_r <= lh_nxt;
      ll_r <= ll_nxt;
    end
  end

  // recombine partial products, all extended to full width first
  assign p_nxt = (PW'(hh_r) <<< (2 * LO)) + (PW'(hl_r) <<< LO) + (PW'(lh_r) <<< LO)
               + PW'(ll_r);

  always_ff @(posedge clk) begin
    if (ctl.en_b) begin
      p_r <= p_nxt;
    end
  end

  assign p = p_r;

endmodule

`default_nettype wire

@@ sv/point_in_triangular_prism_unit.sv @@
// Point-in-triangular-prism test. Each transfer on the input channel carries one
// query point (x, y, z, signed fixed point, COORD_BITS wide) and yields exactly one
// result transfer: inside_res is 1 when the point projects inside triangle A, B, C
// (barycentric u >= 0, v >= 0, u + v < 1, judged exactly without division) and
// A.z <= z <= A.z + prism_length; degenerate is 1, with inside_res 0, when the
// triangle's Gram determinant is zero (the state after reset included). The block
// is a seven-stage pipeline: edge differences, coordinate products, dot products,
// two stages of split wide multiplication, determinant and numerators, final
// compare into the output register. One point is accepted every cycle, and a stalled
// output only stops the stages behind it once they fill up. Configuration is a plain
// write port (index 0..2 vertices A, B, C packed x, y, z from the low bits, index 3
// prism_length) and must only be written while no point is in flight.
`default_nettype none

module point_in_triangular_prism_unit #(
  parameter int COORD_BITS = 21
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // configuration
  input  logic                                cfg_we,
  input  logic [pitp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [pitp_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  // query points
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [COORD_BITS-1:0]        in_point_x,
  input  logic signed [COORD_BITS-1:0]        in_point_y,
  input  logic signed [COORD_BITS-1:0]        in_point_z,
  // results
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                out_inside_res,
  output logic                                out_degenerate
);
  import pitp_pkg::*;

  localparam int CB   = COORD_BITS;
  localparam int VW   = 3 * CB;                  // packed vertex width
  localparam int DW   = CB + 1;                  // coordinate difference
  localparam int PPW  = 2 * DW;                  // one coordinate product
  localparam int DOTW = 2 * DW + 1;              // 3D dot product
  localparam int MW   = 2 * DOTW;                // product of two dot products
  localparam int BW   = MW + 1;                  // determinant and numerators
  localparam int SW   = BW + 2;                  // u + v - det
  localparam int ZW   = ((CB > LEN_BITS) ? CB : LEN_BITS) + 2;  // z bound compare

  typedef logic signed [CB-1:0]   crd_t;
  typedef logic signed [DW-1:0]   diff_t;
  typedef logic signed [PPW-1:0]  prod_t;
  typedef logic signed [DOTW-1:0] dot_t;
  typedef logic signed [MW-1:0]   mul_t;
  typedef logic signed [BW-1:0]   big_t;

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  logic [VW-1:0]       va_r, vb_r, vc_r;
  logic [LEN_BITS-1:0] len_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r  <= '0;
      vb_r  <= '0;
      vc_r  <= '0;
      len_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_VERTEX_A:     va_r  <= cfg_wdata[VW-1:0];
        CFG_VERTEX_B:     vb_r  <= cfg_wdata[VW-1:0];
        CFG_VERTEX_C:     vc_r  <= cfg_wdata[VW-1:0];
        CFG_PRISM_LENGTH: len_r <= cfg_wdata[LEN_BITS-1:0];
        default:          ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // pipeline flow control: a stage may load when it is empty or its
  // occupant moves on in the same cycle
  // ---------------------------------------------------------------------------
  logic [NUM_STAGES:1] vld_r, vld_nxt;
  logic [NUM_STAGES:1] en;

  always_comb begin
    en[NUM_STAGES] = !vld_r[NUM_STAGES] || out_ready;
    for (int k = NUM_STAGES - 1; k >= 1; k--) begin
      en[k] = !vld_r[k] || en[k+1];
    end
  end

  always_comb begin
    vld_nxt = vld_r;
    if (en[1]) begin
      vld_nxt[1] = in_valid;
    end
    for (int k = 2; k <= NUM_STAGES; k++) begin
      if (en[k]) begin
        vld_nxt[k] = vld_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_ready  = en[1];
  assign out_valid = vld_r[NUM_STAGES];

  // ---------------------------------------------------------------------------
  // stage 1: edge vectors e0 = B - C, e1 = A - C, offset w = P - C, z bounds
  // ---------------------------------------------------------------------------
  crd_t                 pt [3];
  diff_t                e0_nxt [3], e1_nxt [3], w_nxt [3];
  diff_t                s1_e0_r [3], s1_e1_r [3], s1_w_r [3];
  logic signed [ZW-1:0] az_x, pz_x, ztop_x;
  logic                 zok_nxt, s1_zok_r;

  assign pt[0] = in_point_x;
  assign pt[1] = in_point_y;
  assign pt[2] = in_point_z;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      e0_nxt[k] = DW'($signed(vb_r[k*CB +: CB])) - DW'($signed(vc_r[k*CB +: CB]));
      e1_nxt[k] = DW'($signed(va_r[k*CB +: CB])) - DW'($signed(vc_r[k*CB +: CB]));
      w_nxt[k]  = DW'(pt[k]) - DW'($signed(vc_r[k*CB +: CB]));
    end
  end

  // the prism spans from A.z up to A.z + prism_length, both ends included
  assign az_x    = ZW'($signed(va_r[2*CB +: CB]));
  assign pz_x    = ZW'(in_point_z);
  assign ztop_x  = az_x + ZW'($signed({1'b0, len_r}));
  assign zok_nxt = (pz_x >= az_x) && (pz_x <= ztop_x);

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s1_e0_r  <= e0_nxt;
      s1_e1_r  <= e1_nxt;
      s1_w_r   <= w_nxt;
      s1_zok_r <= zok_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 2: per-axis products for the five dot products
  // ---------------------------------------------------------------------------
  prod_t s2_p00_r [3], s2_p01_r [3], s2_p02_r [3], s2_p11_r [3], s2_p12_r [3];
  logic  s2_zok_r;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      for (int k = 0; k < 3; k++) begin
        s2_p00_r[k] <= s1_e0_r[k] * s1_e0_r[k];
        s2_p01_r[k] <= s1_e0_r[k] * s1_e1_r[k];
        s2_p02_r[k] <= s1_e0_r[k] * s1_w_r[k];
        s2_p11_r[k] <= s1_e1_r[k] * s1_e1_r[k];
        s2_p12_r[k] <= s1_e1_r[k] * s1_w_r[k];
      end
      s2_zok_r <= s1_zok_r;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 3: dot products (exact, three-term sums)
  // ---------------------------------------------------------------------------
  dot_t d00_nxt, d01_nxt, d02_nxt, d11_nxt, d12_nxt;
  dot_t s3_d00_r, s3_d01_r, s3_d02_r, s3_d11_r, s3_d12_r;
  logic s3_zok_r;

  assign d00_nxt = DOTW'(s2_p00_r[0]) + DOTW'(s2_p00_r[1]) + DOTW'(s2_p00_r[2]);
  assign d01_nxt = DOTW'(s2_p01_r[0]) + DOTW'(s2_p01_r[1]) + DOTW'(s2_p01_r[2]);
  assign d02_nxt = DOTW'(s2_p02_r[0]) + DOTW'(s2_p02_r[1]) + DOTW'(s2_p02_r[2]);
  assign d11_nxt = DOTW'(s2_p11_r[0]) + DOTW'(s2_p11_r[1]) + DOTW'(s2_p11_r[2]);
  assign d12_nxt = DOTW'(s2_p12_r[0]) + DOTW'(s2_p12_r[1]) + DOTW'(s2_p12_r[2]);

  always_ff @(posedge clk) begin
    if (en[3]) begin
      s3_d00_r <= d00_nxt;
      s3_d01_r <= d01_nxt;
      s3_d02_r <= d02_nxt;
      s3_d11_r <= d11_nxt;
      s3_d12_r <= d12_nxt;
      s3_zok_r <= s2_zok_r;
    end
  end

  // ---------------------------------------------------------------------------
  // stages 4 and 5: six wide products, split into partial products
  // ---------------------------------------------------------------------------
  mul_ctl_t mctl;
  mul_t     m_det_a, m_det_b, m_u_a, m_u_b, m_v_a, m_v_b;
  logic     s4_zok_r, s5_zok_r;

  assign mctl.en_a = en[4];
  assign mctl.en_b = en[5];

  // det = d00*d11 - d01^2
  pitp_wmul #(.W(DOTW)) u_mul_det_a (.clk(clk), .ctl(mctl), .a(s3_d00_r), .b(s3_d11_r),
                                     .p(m_det_a));
  pitp_wmul #(.W(DOTW)) u_mul_det_b (.clk(clk), .ctl(mctl), .a(s3_d01_r), .b(s3_d01_r),
                                     .p(m_det_b));
  // u numerator = d11*d02 - d01*d12
  pitp_wmul #(.W(DOTW)) u_mul_u_a (.clk(clk), .ctl(mctl), .a(s3_d11_r), .b(s3_d02_r),
                                   .p(m_u_a));
  pitp_wmul #(.W(DOTW)) u_mul_u_b (.clk(clk), .ctl(mctl), .a(s3_d01_r), .b(s3_d12_r),
                                   .p(m_u_b));
  // v numerator = d00*d12 - d01*d02
  pitp_wmul #(.W(DOTW)) u_mul_v_a (.clk(clk), .ctl(mctl), .a(s3_d00_r), .b(s3_d12_r),
                                   .p(m_v_a));
  pitp_wmul #(.W(DOTW)) u_mul_v_b (.clk(clk), .ctl(mctl), .a(s3_d01_r), .b(s3_d02_r),
                                   .p(m_v_b));

  always_ff @(posedge clk) begin
    if (en[4]) begin
      s4_zok_r <= s3_zok_r;
    end
    if (en[5]) begin
      s5_zok_r <= s4_zok_r;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 6: determinant and barycentric numerators
  // ---------------------------------------------------------------------------
  big_t det_nxt, un_nxt, vn_nxt;
  big_t s6_det_r, s6_un_r, s6_vn_r;
  logic s6_zok_r;

  assign det_nxt = BW'(m_det_a) - BW'(m_det_b);
  assign un_nxt  = BW'(m_u_a) - BW'(m_u_b);
  assign vn_nxt  = BW'(m_v_a) - BW'(m_v_b);

  always_ff @(posedge clk) begin
    if (en[6]) begin
      s6_det_r <= det_nxt;
      s6_un_r  <= un_nxt;
      s6_vn_r  <= vn_nxt;
      s6_zok_r <= s5_zok_r;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 7: sign tests against det >= 0, output register
  // ---------------------------------------------------------------------------
  logic signed [SW-1:0] sum_x;
  logic                 degen_nxt, inside_nxt;
  logic                 out_inside_r, out_degen_r;

  assign sum_x      = SW'(s6_un_r) + SW'(s6_vn_r) - SW'(s6_det_r);
  assign degen_nxt  = (s6_det_r == '0);
  assign inside_nxt = !degen_nxt && !s6_un_r[BW-1] && !s6_vn_r[BW-1]
                   && sum_x[SW-1] && s6_zok_r;

  always_ff @(posedge clk) begin
    if (en[7]) begin
      out_inside_r <= inside_nxt;
      out_degen_r  <= degen_nxt;
    end
  end

  assign out_inside_res = out_inside_r;
  assign out_degenerate = out_degen_r;

endmodule

`default_nettype wire

@@ sv/pitp_chk.sv @@
`default_nettype none

module pitp_chk (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_inside_res,
  input logic out_degenerate
);

  // a held result keeps its value until transferred
  ast_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable({out_inside_res, out_degenerate}))
    else $error("result changed while stalled");

  // a degenerate triangle never reports a point inside
  ast_degen_outside: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_inside_res && out_degenerate))
    else $error("inside and degenerate both set");

  // input back-pressure only comes from a stalled output
  ast_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without output stall");

  // a full pipeline with the output taken accepts a new point
  ast_ready_flow: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("input stalled while output drains");

endmodule

bind point_in_triangular_prism_unit pitp_chk u_pitp_chk (.*);

`default_nettype wire

@@ test/point_in_triangular_prism_unit_tb.sv @@
`timescale 1ns / 100ps

module point_in_triangular_prism_unit_tb;
  import pitp_pkg::*;

  localparam int COORD_W = 21;
  localparam longint CMAX = (1 << 20) - 1;
  localparam longint CMIN = -(1 << 20);
  localparam int RANDOM_PHASES = 16;
  localparam int RANDOM_PER_PHASE = 53;
  localparam int DRAIN_GUARD = 4000;

  // expected verdicts for points in flight, plus a private copy of the registers
  class point_verdict_board;
    typedef struct packed {
      logic in_prism;
      logic degen;
    } verdict_t;

    logic [CFG_DATA_W-1:0] vert_a, vert_b, vert_c;
    longint span;
    verdict_t expected_verdicts[$];
    int mismatches, checked, inside_hits, degen_hits;

    function new();
      vert_a = '0;
      vert_b = '0;
      vert_c = '0;
      span = 0;
      mismatches = 0;
      checked = 0;
      inside_hits = 0;
      degen_hits = 0;
    endfunction

    static function longint coord(logic [CFG_DATA_W-1:0] packed_v, int k);
      logic signed [COORD_W-1:0] c;
      c = packed_v[k*COORD_W +: COORD_W];
      return longint'(c);
    endfunction

    static function logic signed [127:0] wide_mul(longint x, longint y);
      logic signed [127:0] wx, wy;
      wx = x;
      wy = y;
      return wx * wy;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_VERTEX_A: vert_a = data;
        CFG_VERTEX_B: vert_b = data;
        CFG_VERTEX_C: vert_c = data;
        CFG_PRISM_LENGTH: span = data[LEN_BITS-1:0];
        default: ;
      endcase
    endfunction

    // barycentric test without division: u, v judged against the gram determinant
    function verdict_t predict_verdict(logic signed [COORD_W-1:0] px, py, pz);
      longint e0[3], e1[3], w[3], p[3];
      longint d00, d01, d02, d11, d12, az;
      logic signed [127:0] det, un, vn;
      verdict_t v;
      p[0] = px;
      p[1] = py;
      p[2] = pz;
      for (int k = 0; k < 3; k++) begin
        e0[k] = coord(vert_b, k) - coord(vert_c, k);
        e1[k] = coord(vert_a, k) - coord(vert_c, k);
        w[k] = p[k] - coord(vert_c, k);
      end
      d00 = e0[0] * e0[0] + e0[1] * e0[1] + e0[2] * e0[2];
      d01 = e0[0] * e1[0] + e0[1] * e1[1] + e0[2] * e1[2];
      d02 = e0[0] * w[0] + e0[1] * w[1] + e0[2] * w[2];
      d11 = e1[0] * e1[0] + e1[1] * e1[1] + e1[2] * e1[2];
      d12 = e1[0] * w[0] + e1[1] * w[1] + e1[2] * w[2];
      det = wide_mul(d00, d11) - wide_mul(d01, d01);
      un = wide_mul(d11, d02) - wide_mul(d01, d12);
      vn = wide_mul(d00, d12) - wide_mul(d01, d02);
      az = coord(vert_a, 2);
      v.degen = (det == 0);
      v.in_prism = 1'b0;
      if (!v.degen)
        v.in_prism = (un >= 0) && (vn >= 0) && (un + vn - det < 0) &&
                     (p[2] >= az) && (p[2] <= az + span);
      return v;
    endfunction

    function void note_point(logic signed [COORD_W-1:0] px, py, pz);
      expected_verdicts.push_back(predict_verdict(px, py, pz));
    endfunction

    function int pending();
      return expected_verdicts.size();
    endfunction

    task report(string what);
      mismatches++;
      $display("mismatch at %0t ns: %s", $time, what);
    endtask

    task check_result(logic got_in, logic degen);
      verdict_t want;
      if (expected_verdicts.size() == 0) begin
        report("result transfer with no point pending");
        return;
      end
      want = expected_verdicts.pop_front();
      checked++;
      if (want.in_prism) inside_hits++;
      if (want.degen) degen_hits++;
      if (got_in !== want.in_prism)
        report($sformatf("inside_res %b, expected %b (result %0d)", got_in, want.in_prism,
                         checked));
      if (degen !== want.degen)
        report($sformatf("degenerate %b, expected %b (result %0d)", degen, want.degen,
                         checked));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic in_valid;
  logic in_ready;
  logic signed [COORD_W-1:0] in_point_x, in_point_y, in_point_z;
  logic out_valid;
  logic out_ready;
  logic out_inside_res;
  logic out_degenerate;

  point_verdict_board sb;
  bit send_idle, recv_idle;   // per-phase switches for random gaps on each side
  int points_sent;
  int settings_used;

  always #6 clk = ~clk;

  point_in_triangular_prism_unit #(
    .COORD_BITS(COORD_W)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_point_x(in_point_x),
    .in_point_y(in_point_y),
    .in_point_z(in_point_z),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_inside_res(out_inside_res),
    .out_degenerate(out_degenerate)
  );

  function automatic longint clamp_coord(longint v);
    if (v > CMAX) return CMAX;
    if (v < CMIN) return CMIN;
    return v;
  endfunction

  // uniform in [-mag, mag-1], mag at most 2^20
  function automatic longint rand_coord(int mag);
    return clamp_coord(longint'($urandom_range(0, 2 * mag - 1)) - mag);
  endfunction

  // x in the low bits, then y, then z
  function automatic logic [CFG_DATA_W-1:0] pack_vertex(longint x, longint y, longint z);
    return {z[COORD_W-1:0], y[COORD_W-1:0], x[COORD_W-1:0]};
  endfunction

  function automatic logic [CFG_DATA_W-1:0] rand_word();
    return CFG_DATA_W'({$urandom, $urandom});
  endfunction

  // one transfer on the point channel; valid stays up across back-to-back points
  task automatic send_point(longint px, longint py, longint pz);
    int gap;
    gap = send_idle ? $urandom_range(0, 11) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_point_x <= px[COORD_W-1:0];
    in_point_y <= py[COORD_W-1:0];
    in_point_z <= pz[COORD_W-1:0];
    do @(posedge clk); while (in_ready !== 1'b1);
    sb.note_point(px[COORD_W-1:0], py[COORD_W-1:0], pz[COORD_W-1:0]);
    points_sent++;
  endtask

  // stop sending and let every point in flight come out
  task automatic wait_drained();
    int guard;
    guard = 0;
    in_valid <= 1'b0;
    while (sb.pending() > 0 && guard < DRAIN_GUARD) begin
      @(posedge clk);
      guard++;
    end
    repeat (NUM_STAGES + 2) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    sb.set_reg(idx, data);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // registers only change with the pipeline empty
  task automatic apply_setting(logic [CFG_DATA_W-1:0] a, logic [CFG_DATA_W-1:0] b,
                               logic [CFG_DATA_W-1:0] c, logic [CFG_DATA_W-1:0] len);
    wait_drained();
    write_reg(CFG_VERTEX_A, a);
    write_reg(CFG_VERTEX_B, b);
    write_reg(CFG_VERTEX_C, c);
    write_reg(CFG_PRISM_LENGTH, len);
    settings_used++;
  endtask

  // prism length: zero, all ones, fully random or short; junk above bit 19 where it fits
  function automatic logic [CFG_DATA_W-1:0] rand_length();
    logic [CFG_DATA_W-1:0] junk;
    junk = rand_word();
    case ($urandom_range(0, 3))
      0: return {junk[CFG_DATA_W-1:LEN_BITS], {LEN_BITS{1'b0}}};
      1: return {CFG_DATA_W{1'b1}};
      2: return junk;
      default: return CFG_DATA_W'($urandom_range(0, 4096));
    endcase
  endfunction

  function automatic longint rand_extreme();
    case ($urandom_range(0, 3))
      0: return CMIN;
      1: return CMAX;
      2: return 0;
      default: return -1;
    endcase
  endfunction

  task automatic choose_setting(int kind);
    longint ax, ay, cx, cy, zc;
    int mag;
    logic [CFG_DATA_W-1:0] va, vb, vc;
    mag = 1 << $urandom_range(6, 20);
    case (kind)
      0, 1, 2: begin
        // flat triangle, the usual prism case
        zc = rand_coord(1 << 20);
        va = pack_vertex(rand_coord(mag), rand_coord(mag), zc);
        vb = pack_vertex(rand_coord(mag), rand_coord(mag), zc);
        vc = pack_vertex(rand_coord(mag), rand_coord(mag), zc);
      end
      3, 4: begin
        // tilted plane, off-plane points are projected
        va = pack_vertex(rand_coord(mag), rand_coord(mag), rand_coord(mag));
        vb = pack_vertex(rand_coord(mag), rand_coord(mag), rand_coord(mag));
        vc = pack_vertex(rand_coord(mag), rand_coord(mag), rand_coord(mag));
      end
      5: begin
        va = rand_word();
        vb = rand_word();
        vc = rand_word();
      end
      6: begin
        va = pack_vertex(rand_extreme(), rand_extreme(), rand_extreme());
        vb = pack_vertex(rand_extreme(), rand_extreme(), rand_extreme());
        vc = pack_vertex(rand_extreme(), rand_extreme(), rand_extreme());
      end
      default: begin
        // zero-area triangles: coincident vertices or three on a line
        ax = rand_coord(1 << 18);
        ay = rand_coord(1 << 18);
        cx = rand_coord(1 << 18);
        cy = rand_coord(1 << 18);
        zc = rand_coord(1 << 18);
        va = pack_vertex(ax, ay, zc);
        vc = pack_vertex(cx, cy, zc - 5);
        case ($urandom_range(0, 2))
          0: vb = vc;
          1: vb = pack_vertex(2 * ax - cx, 2 * ay - cy, 2 * zc - (zc - 5));
          default: begin
            vb = va;
            vc = va;
          end
        endcase
      end
    endcase
    apply_setting(va, vb, vc, rand_length());
  endtask

  // mostly points on or near the triangle with z near the prism bounds, some noise
  task automatic random_point(output longint px, output longint py, output longint pz);
    longint va[3], vb[3], vc[3], q[3];
    longint s, t, az, top;
    int pick;
    for (int k = 0; k < 3; k++) begin
      va[k] = point_verdict_board::coord(sb.vert_a, k);
      vb[k] = point_verdict_board::coord(sb.vert_b, k);
      vc[k] = point_verdict_board::coord(sb.vert_c, k);
    end
    pick = $urandom_range(0, 99);
    if (pick < 20) begin
      for (int k = 0; k < 3; k++) q[k] = rand_coord(1 << 20);
    end else begin
      if (pick < 30) begin
        // on a vertex
        case ($urandom_range(0, 2))
          0: begin s = 0; t = 0; end
          1: begin s = 1024; t = 0; end
          default: begin s = 0; t = 1024; end
        endcase
      end else if (pick < 45) begin
        // along an edge, nudged across it now and then
        s = $urandom_range(0, 1024);
        case ($urandom_range(0, 2))
          0: t = 0;
          1: begin t = s; s = 0; end
          default: t = 1024 - s;
        endcase
        s += longint'($urandom_range(0, 2)) - 1;
        t += longint'($urandom_range(0, 2)) - 1;
      end else begin
        s = $urandom_range(0, 1024);
        t = $urandom_range(0, 1024 - s);
      end
      for (int k = 0; k < 3; k++)
        q[k] = clamp_coord(vc[k] + (s * (vb[k] - vc[k]) + t * (va[k] - vc[k])) / 1024);
      az = va[2];
      top = az + sb.span;
      case ($urandom_range(0, 5))
        0: q[2] = az;
        1: q[2] = top;
        2: q[2] = az - 1;
        3: q[2] = top + 1;
        4: q[2] = az + $urandom_range(0, sb.span);
        default: ;  // keep the height on the triangle plane
      endcase
      q[2] = clamp_coord(q[2]);
    end
    px = q[0];
    py = q[1];
    pz = q[2];
  endtask

  // result side: random stall per result, then ready held until a transfer
  initial begin
    int stall;
    out_ready <= 1'b0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      stall = recv_idle ? $urandom_range(0, 11) : 0;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
    end
  end

  // every result transfer is checked against the oldest pending verdict
  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1)
      sb.check_result(out_inside_res, out_degenerate);
  end

  initial begin
    longint px, py, pz;
    sb = new();
    points_sent = 0;
    settings_used = 0;
    send_idle = 1'b1;
    recv_idle = 1'b1;
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= CFG_VERTEX_A;
    cfg_wdata <= '0;
    in_valid <= 1'b0;
    in_point_x <= '0;
    in_point_y <= '0;
    in_point_z <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // registers after reset are all zero: degenerate, never inside
    send_point(CMIN, CMIN, CMIN);
    send_point(CMAX, CMAX, CMAX);
    send_point(0, 0, 0);

    // right triangle in the plane z = 100, legs 1024, so u = x/1024 and v = y/1024
    apply_setting(pack_vertex(0, 1024, 100), pack_vertex(1024, 0, 100),
                  pack_vertex(0, 0, 100), 512);
    send_point(100, 100, 300);        // plainly inside
    send_point(0, 0, 100);            // reference vertex, z on the lower bound
    send_point(0, 500, 612);          // on the u = 0 edge, z on the upper bound
    send_point(512, 512, 200);        // u + v exactly 1: outside
    send_point(511, 512, 200);        // just short of the far edge
    send_point(-1, 10, 200);          // u just negative
    send_point(10, -1, 200);          // v just negative
    send_point(100, 100, 99);         // one below the base
    send_point(100, 100, 613);        // one above the top
    send_point(100, 100, CMIN);
    send_point(100, 100, CMAX);

    // three vertices on a line, then all three coincident
    apply_setting(pack_vertex(100, 200, 300), pack_vertex(200, 400, 600),
                  pack_vertex(0, 0, 0), 1000);
    send_point(50, 100, 300);
    apply_setting(pack_vertex(7, 7, 7), pack_vertex(7, 7, 7), pack_vertex(7, 7, 7), 1000);
    send_point(7, 7, 7);

    // vertices at the coordinate limits, length register all ones
    apply_setting(pack_vertex(CMAX, 0, CMIN), pack_vertex(CMIN, CMAX, 0),
                  pack_vertex(0, CMIN, CMAX), {CFG_DATA_W{1'b1}});
    send_point(0, 0, CMIN);
    send_point(CMAX, CMAX, CMAX);
    send_point(CMIN, CMIN, -1);
    send_point(-1, -1, -1);

    // tilted plane: a point off the plane still counts by its projection
    apply_setting(pack_vertex(0, 1024, 0), pack_vertex(1024, 0, 1024),
                  pack_vertex(0, 0, 0), 2048);
    send_point(512, 100, 0);
    send_point(100, 100, 2048);
    wait_drained();

    // random settings, each with its own mix of gaps on the two sides
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      choose_setting(ph % 8);
      send_idle = (ph % 4 == 0) || (ph % 4 == 2);
      recv_idle = (ph % 4 == 0) || (ph % 4 == 3);
      repeat (RANDOM_PER_PHASE) begin
        random_point(px, py, pz);
        send_point(px, py, pz);
      end
    end
    wait_drained();

    if (sb.pending() > 0)
      sb.report($sformatf("%0d results never arrived", sb.pending()));
    $display("covered %0d points over %0d register settings, corner points first",
             points_sent, settings_used);
    $display("%0d results checked: %0d inside, %0d degenerate", sb.checked,
             sb.inside_hits, sb.degen_hits);
    if (sb.mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // hang guard, far beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
